// ----- sv/vsr_pkg.sv -----
// Shared constants and register codes for the vector smootherstep remap block.
`default_nettype none
package vsr_pkg;
	localparam int VALUE_WIDTH_DEF = 20;
	localparam int FRAC_BITS_DEF   = 12;
	localparam int CFG_AW          = 3;

	typedef enum logic [CFG_AW-1:0] {
		REG_IN_LO  = 3'd0,
		REG_IN_HI  = 3'd1,
		REG_OUT_LO = 3'd2,
		REG_OUT_HI = 3'd3
	} reg_idx_t;
endpackage
`default_nettype wire

// ----- sv/vector_smootherstep_remap.sv -----
// Top level: pipelined quintic smootherstep remap of a three-lane fixed-point vector.
//
//  channel | dir | group                           | contents
//  s_*     | in  | s_tvalid/s_tready/s_tdata       | one request: in_x, in_y, in_z
//  m_*     | out | m_tvalid/m_tready/m_tdata       | one result: out_x, out_y, out_z
//  cfg_*   | in  | cfg_we/cfg_addr/cfg_data        | bound registers, write only
//
// The pipe has one setup stage, one restoring-divider stage per quotient
// bit, then six stages for the polynomial, the range multiply and the
// saturating add. One request enters per cycle while the pipe advances.
// The whole pipe moves as one: it advances whenever the output register is
// empty or taken; holding m_tready low freezes every stage, s_tready follows.
// arst_n clears valid bits and loads the register reset values.
`default_nettype none
module vector_smootherstep_remap #(
	parameter int VALUE_WIDTH = vsr_pkg::VALUE_WIDTH_DEF,
	parameter int FRAC_BITS   = vsr_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// in_x, in_y, in_z from bit 0 up, zero padded to bytes
	input  wire logic [((3*VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// out_x, out_y, out_z from bit 0 up, zero padded to bytes
	output logic [((3*VALUE_WIDTH+7)/8)*8-1:0]          m_tdata,
	input  wire logic                                   cfg_we,
	input  wire logic [vsr_pkg::CFG_AW-1:0]             cfg_addr,
	input  wire logic [3*VALUE_WIDTH-1:0]               cfg_data
);
	localparam int VW   = VALUE_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int TDW  = ((3*VW+7)/8)*8;
	localparam int TW   = F + 1;          // t in [0, 1.0]
	localparam int T2W  = 2*TW;
	localparam int T3W  = 2*F + 1;
	localparam int PNW  = 2*F + 5;
	localparam int PW4  = F + 4;          // p up to 10.0
	localparam int SPW  = T3W + PW4;
	localparam int PW   = TW + 1 + VW + 1;
	localparam int RW   = VW + 4;
	localparam int NST  = F + 7;          // total stages

	localparam logic [VW-1:0]     ONE_V  = VW'(1) << F;
	localparam logic [TW-1:0]     ONE_T  = TW'(1) << F;
	localparam logic [PNW-1:0]    TEN_2F = PNW'(10) << (2*F);
	localparam logic signed [RW-1:0] MAXV = RW'((1 << (VW-1)) - 1);
	localparam logic signed [RW-1:0] MINV = -RW'(1 << (VW-1));

	// configuration registers
	logic [3*VW-1:0] in_lo_q, in_hi_q, out_lo_q, out_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_lo_q  <= '0;
			in_hi_q  <= {3{ONE_V}};
			out_lo_q <= '0;
			out_hi_q <= {3{ONE_V}};
		end else if (cfg_we) begin
			case (cfg_addr)
				vsr_pkg::REG_IN_LO:  in_lo_q  <= cfg_data;
				vsr_pkg::REG_IN_HI:  in_hi_q  <= cfg_data;
				vsr_pkg::REG_OUT_LO: out_lo_q <= cfg_data;
				vsr_pkg::REG_OUT_HI: out_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: output empty or being taken
	logic adv;
	logic vld_s [0:NST-1];
	assign adv      = !vld_s[NST-1] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= s_tvalid;
			for (int k = 1; k < NST; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// stage 1: sign-normalized numerator/denominator, clamp cases resolved
	logic [VW-1:0] rem_s [0:F][0:2];
	logic [VW-1:0] den_s [0:F][0:2];
	logic [F-1:0]  quo_s [0:F][0:2];
	logic          fix_s [0:F][0:2];
	logic          tv_s  [0:F][0:2];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [VW:0] n, d;
				d = signed'({in_hi_q[i*VW+VW-1], in_hi_q[i*VW +: VW]})
				  - signed'({in_lo_q[i*VW+VW-1], in_lo_q[i*VW +: VW]});
				n = signed'({s_tdata[i*VW+VW-1], s_tdata[i*VW +: VW]})
				  - signed'({in_lo_q[i*VW+VW-1], in_lo_q[i*VW +: VW]});
				if (d < 0) begin
					n = -n;
					d = -d;
				end
				// equal bounds reduce to n >= 0, same compare as the upper clamp
				tv_s[0][i]  <= (n >= d);
				fix_s[0][i] <= (d == 0) || (n <= 0) || (n >= d);
				rem_s[0][i] <= n[VW-1:0];
				den_s[0][i] <= d[VW-1:0];
				quo_s[0][i] <= '0;
			end
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 1; k <= F; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					logic [VW:0] r2;
					logic        ge;
					r2 = {rem_s[k-1][i], 1'b0};
					ge = (r2 >= {1'b0, den_s[k-1][i]});
					rem_s[k][i] <= ge ? VW'(r2 - {1'b0, den_s[k-1][i]}) : r2[VW-1:0];
					quo_s[k][i] <= {quo_s[k-1][i][F-2:0], ge};
					den_s[k][i] <= den_s[k-1][i];
					fix_s[k][i] <= fix_s[k-1][i];
					tv_s[k][i]  <= tv_s[k-1][i];
				end
			end
		end
	end

	// polynomial and remap stages
	logic [TW-1:0]  t_s1  [0:2];
	logic [TW-1:0]  t_s2  [0:2];
	logic [T2W-1:0] t2_s2 [0:2];
	logic [T3W-1:0] t3_s3 [0:2];
	logic [PW4-1:0] p_s3  [0:2];
	logic [TW-1:0]  s_s4  [0:2];
	logic signed [PW-1:0] pr_s5 [0:2];
	logic [VW-1:0]  o_s6  [0:2];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				logic [3*TW-1:0] t3w;
				logic [PNW-1:0]  pn;
				logic [SPW-1:0]  sp;
				logic signed [VW:0] dif;
				logic signed [RW-1:0] r;
				t_s1[i]  <= fix_s[F][i] ? (tv_s[F][i] ? ONE_T : '0) : {1'b0, quo_s[F][i]};
				t_s2[i]  <= t_s1[i];
				t2_s2[i] <= T2W'(t_s1[i]) * T2W'(t_s1[i]);
				t3w = (3*TW)'(t2_s2[i]) * (3*TW)'(t_s2[i]);
				t3_s3[i] <= T3W'(t3w >> F);
				pn = PNW'(6) * PNW'(t2_s2[i]) + TEN_2F
				   - ((PNW'(15) * PNW'(t_s2[i])) << F);
				p_s3[i] <= PW4'(pn >> F);
				sp = SPW'(t3_s3[i]) * SPW'(p_s3[i]);
				s_s4[i] <= TW'(sp >> (2*F));
				dif = signed'({out_hi_q[i*VW+VW-1], out_hi_q[i*VW +: VW]})
				    - signed'({out_lo_q[i*VW+VW-1], out_lo_q[i*VW +: VW]});
				pr_s5[i] <= PW'(signed'({1'b0, s_s4[i]})) * PW'(dif);
				// arithmetic shift floors toward minus infinity
				r = RW'(signed'(out_lo_q[i*VW +: VW])) + RW'(pr_s5[i] >>> F);
				if (r > MAXV)      o_s6[i] <= MAXV[VW-1:0];
				else if (r < MINV) o_s6[i] <= MINV[VW-1:0];
				else               o_s6[i] <= r[VW-1:0];
			end
		end
	end

	assign m_tdata = TDW'({o_s6[2], o_s6[1], o_s6[0]});

	a_ready_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow output stall");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s[0])
		else $error("accepted request lost at stage one");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(vld_s[0])))
		else $error("pipe moved during stall");
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the vector smootherstep remap block.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	localparam int VW   = 20;
	localparam int FB   = 12;
	localparam int DW   = ((3*VW+7)/8)*8;
	localparam int ONE  = 1 << FB;
	localparam int VMAX = (1 << (VW-1)) - 1;
	localparam int VMIN = -(1 << (VW-1));
	// pipe depth, as NST in the top level, plus slack
	localparam int SETTLE = FB + 7 + 8;
	// addresses with no register behind them
	localparam logic [vsr_pkg::CFG_AW-1:0] REG_NONE_A = 3'd4;
	localparam logic [vsr_pkg::CFG_AW-1:0] REG_NONE_B = 3'd7;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [DW-1:0] s_tdata;     // in_x, in_y, in_z, zero pad
	logic m_tvalid;
	logic m_tready;
	logic [DW-1:0] m_tdata;     // out_x, out_y, out_z, zero pad
	logic cfg_we;
	logic [vsr_pkg::CFG_AW-1:0] cfg_addr;
	logic [3*VW-1:0] cfg_data;

	vector_smootherstep_remap DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	// mirror of the four bound registers, index = reg_idx_t
	logic [3*VW-1:0] bounds [4];
	// remapped vectors still owed by the block, oldest first
	logic [3*VW-1:0] remap_due [$];

	int errors;
	int src_idle_pct;
	int snk_idle_pct;
	int hold_left;   // receiver hold-off, counted down by the receiver

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// limit: far above the slowest legal run
	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic longint lane(input logic [3*VW-1:0] r, input int i);
		logic signed [VW-1:0] v;
		v = r[i*VW +: VW];
		return longint'(v);
	endfunction

	// clamped ramp position, F fraction bits
	function automatic longint ramp_pos(input longint v, input longint lo, input longint hi);
		longint num, den;
		num = v - lo;
		den = hi - lo;
		if (den == 0)
			return (v >= lo) ? ONE : 0;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		if (num <= 0)
			return 0;
		if (num >= den)
			return ONE;
		return (num << FB) / den;
	endfunction

	// 6t^5 - 15t^4 + 10t^3 in the truncation order of the datapath
	function automatic longint smootherstep(input longint t);
		longint t2, t3, p;
		t2 = t * t;
		t3 = (t2 * t) >> FB;
		p  = (6 * t2 + 10 * ONE * ONE - 15 * t * ONE) >> FB;
		return (t3 * p) >> (2 * FB);
	endfunction

	function automatic logic [3*VW-1:0] remap_vec(input logic [3*VW-1:0] vin);
		logic [3*VW-1:0] r;
		longint s, olo, ohi, o;
		for (int i = 0; i < 3; i++) begin
			s = smootherstep(ramp_pos(lane(vin, i), lane(bounds[vsr_pkg::REG_IN_LO], i),
				lane(bounds[vsr_pkg::REG_IN_HI], i)));
			olo = lane(bounds[vsr_pkg::REG_OUT_LO], i);
			ohi = lane(bounds[vsr_pkg::REG_OUT_HI], i);
			o = olo + ((s * (ohi - olo)) >>> FB);   // floor
			if (o > VMAX) o = VMAX;
			if (o < VMIN) o = VMIN;
			r[i*VW +: VW] = o[VW-1:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("%0t  %s: expected %0d, got %0d", $time, what, want, got);
		errors++;
	endtask

	// one request; idles first, never drops valid between back-to-back requests
	task automatic send_vec(input logic [3*VW-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(DW-3*VW){1'b0}}, v};
		do @(posedge clk); while (!s_tready);
		remap_due.push_back(remap_vec(v));
	endtask

	task automatic go_quiet();
		s_tvalid <= 1'b0;
		while (remap_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_bounds(input logic [vsr_pkg::CFG_AW-1:0] idx,
		input logic [3*VW-1:0] val);
		go_quiet();
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= vsr_pkg::REG_OUT_HI)
			bounds[idx] = val;
	endtask

	function automatic logic [3*VW-1:0] pack3(input longint x, input longint y, input longint z);
		logic [3*VW-1:0] r;
		r[VW-1:0]      = x[VW-1:0];
		r[2*VW-1:VW]   = y[VW-1:0];
		r[3*VW-1:2*VW] = z[VW-1:0];
		return r;
	endfunction

	function automatic logic [3*VW-1:0] rand_vec();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[3*VW-1:0];
	endfunction

	// mostly near the active input window so the curve interior is hit
	function automatic logic [3*VW-1:0] near_window();
		longint v[3], lo, hi, span;
		for (int i = 0; i < 3; i++) begin
			lo = lane(bounds[vsr_pkg::REG_IN_LO], i);
			hi = lane(bounds[vsr_pkg::REG_IN_HI], i);
			span = (hi > lo) ? hi - lo : lo - hi;
			if ($urandom_range(3) == 0 || span == 0)
				v[i] = lane(rand_vec(), 0);
			else
				v[i] = ((lo < hi) ? lo : hi) - span / 4 + $urandom_range(span + span / 2);
			if (v[i] > VMAX) v[i] = VMAX;
			if (v[i] < VMIN) v[i] = VMIN;
		end
		return pack3(v[0], v[1], v[2]);
	endfunction

	// random window per lane: narrow, wide, reversed or degenerate
	task automatic load_random_bounds();
		longint lo[3], hi[3], w;
		for (int i = 0; i < 3; i++) begin
			lo[i] = $signed(20'($urandom));
			case ($urandom_range(3))
				0: w = $urandom_range(1, 64);
				1: w = $urandom_range(1, 1 << 14);
				2: w = -$signed({1'b0, 18'($urandom)});
				default: w = 0;
			endcase
			hi[i] = lo[i] + w;
			if (hi[i] > VMAX) hi[i] = VMAX;
			if (hi[i] < VMIN) hi[i] = VMIN;
		end
		write_bounds(vsr_pkg::REG_IN_LO, pack3(lo[0], lo[1], lo[2]));
		write_bounds(vsr_pkg::REG_IN_HI, pack3(hi[0], hi[1], hi[2]));
		write_bounds(vsr_pkg::REG_OUT_LO, rand_vec());
		write_bounds(vsr_pkg::REG_OUT_HI, rand_vec());
	endtask

	// receiver: random or held tready, checks every result taken
	always @(posedge clk) begin
		logic [3*VW-1:0] want;
		if (m_tvalid && m_tready) begin
			if (remap_due.size() == 0) begin
				report_mismatch("result with nothing pending", 0,
					longint'(m_tdata[3*VW-1:0]));
			end else begin
				want = remap_due.pop_front();
				if (m_tdata[VW-1:0] != want[VW-1:0])
					report_mismatch("out_x", lane(want, 0), lane(m_tdata[3*VW-1:0], 0));
				if (m_tdata[2*VW-1:VW] != want[2*VW-1:VW])
					report_mismatch("out_y", lane(want, 1), lane(m_tdata[3*VW-1:0], 1));
				if (m_tdata[3*VW-1:2*VW] != want[3*VW-1:2*VW])
					report_mismatch("out_z", lane(want, 2), lane(m_tdata[3*VW-1:0], 2));
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// reset bounds: unit window in and out
	task automatic test_reset_defaults();
		bounds[vsr_pkg::REG_IN_LO]  = '0;
		bounds[vsr_pkg::REG_IN_HI]  = pack3(ONE, ONE, ONE);
		bounds[vsr_pkg::REG_OUT_LO] = '0;
		bounds[vsr_pkg::REG_OUT_HI] = pack3(ONE, ONE, ONE);
		send_vec(pack3(0, ONE, ONE / 2));
		send_vec(pack3(ONE / 4, 3 * ONE / 4, 1));
		send_vec(pack3(VMIN, VMAX, -1));
	endtask

	// full-scale input and output ranges, field extremes and bit toggles
	task automatic test_field_extremes();
		write_bounds(vsr_pkg::REG_IN_LO, pack3(VMIN, VMIN, VMIN));
		write_bounds(vsr_pkg::REG_IN_HI, pack3(VMAX, VMAX, VMAX));
		write_bounds(vsr_pkg::REG_OUT_LO, pack3(VMAX, VMIN, VMIN));
		write_bounds(vsr_pkg::REG_OUT_HI, pack3(VMIN, VMAX, VMAX));
		send_vec(pack3(VMIN, VMAX, 0));
		send_vec(pack3(VMAX, VMIN, -1));
		send_vec(pack3(0, 1, VMIN + 1));
		send_vec({3*VW{1'b1}});
		send_vec({(3*VW/2){2'b01}});
		send_vec({(3*VW/2){2'b10}});
	endtask

	// equal bounds step, reversed window, ignored register addresses
	task automatic test_bound_cases();
		write_bounds(vsr_pkg::REG_IN_LO, pack3(100, -5000, VMIN));
		write_bounds(vsr_pkg::REG_IN_HI, pack3(100, 5000, VMIN));   // x, z degenerate
		write_bounds(vsr_pkg::REG_OUT_LO, pack3(-ONE, 0, -3 * ONE));
		write_bounds(vsr_pkg::REG_OUT_HI, pack3(ONE, ONE, 3 * ONE));
		send_vec(pack3(100, -5000, VMIN));
		send_vec(pack3(99, 5000, VMAX));
		// reversed window on y
		write_bounds(vsr_pkg::REG_IN_HI, pack3(100, -6000, VMIN));
		write_bounds(vsr_pkg::REG_IN_LO, pack3(100, 6000, VMIN));
		send_vec(pack3(101, 0, VMIN));
		send_vec(pack3(-1, -6000, 0));
		send_vec(pack3(0, 7000, 0));
		send_vec(pack3(0, 1234, 0));
		// unmapped addresses must leave the bounds alone
		write_bounds(REG_NONE_A, rand_vec());
		write_bounds(REG_NONE_B, {3*VW{1'b1}});
		send_vec(pack3(100, 2500, VMIN));
		send_vec(pack3(100, -2500, VMIN));
	endtask

	task automatic test_random_phase(input int n);
		load_random_bounds();
		for (int k = 0; k < n; k++) begin
			if (k % 50 == 49)
				load_random_bounds();
			send_vec(($urandom_range(4) == 0) ? rand_vec() : near_window());
		end
	endtask

	// long receiver hold-off while requests keep coming: pipe fills, input stalls
	task automatic test_backpressure();
		go_quiet();
		hold_left = 150;
		for (int k = 0; k < 60; k++)
			send_vec(near_window());
	endtask

	initial begin
		errors = 0;
		hold_left = 0;
		src_idle_pct = 38;
		snk_idle_pct = 62;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		cfg_we   = 1'b0;
		cfg_addr = vsr_pkg::REG_IN_LO;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_bound_cases();
		test_random_phase(200);
		src_idle_pct = 62;
		snk_idle_pct = 38;
		test_random_phase(200);
		test_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_phase(200);

		go_quiet();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/vsr_pkg.sv
sv/vector_smootherstep_remap.sv
bench/tb.sv
